[hw/rtl/periodic_task_tick_scheduler_core_macros.svh]
// Assertion macros for the periodic task tick scheduler.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_CORE_MACROS_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PTTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PTTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ptts_pkg.sv]
// Shared types and codes for the periodic task tick scheduler.
// No dependencies; used by ptts_ctrl, ptts_dp and the top level.
package ptts_pkg;

  // operation codes
  localparam logic [2:0] OpCreate  = 3'd0;
  localparam logic [2:0] OpDelete  = 3'd1;
  localparam logic [2:0] OpSuspend = 3'd2;
  localparam logic [2:0] OpResume  = 3'd3;
  localparam logic [2:0] OpTick    = 3'd4;

  // result kinds
  localparam logic [1:0] KindAck      = 2'd0;
  localparam logic [1:0] KindDispatch = 2'd1;
  localparam logic [1:0] KindIdle     = 2'd2;

  // status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StOccupied = 2'd1;
  localparam logic [1:0] StRange    = 2'd2;

  // dispatches per tick are capped
  localparam int unsigned MaxResults = 8;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  slot;
    logic [15:0] period;
    logic [15:0] first_delay;
    logic [15:0] task_handle;
  } ptts_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [5:0]  dispatched_slot;
    logic [15:0] dispatched_handle;
    logic        last;
  } ptts_out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch input beat, clear tick bookkeeping
    logic exec;     // run latched command, emit acknowledge
    logic step;     // process current slot of a tick walk
    logic flush;    // emit closing result of a tick
  } ptts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_tick;   // incoming beat is a tick
    logic out_free;  // output register can take a beat this cycle
    logic stall;     // current slot is due but the held dispatch cannot leave
  } ptts_sts_t;

endpackage

[hw/rtl/ptts_ctrl.sv]
// Sequencer for the periodic task tick scheduler: accepts beats, runs commands
// and walks the slot table on a tick. Depends on ptts_pkg.
module ptts_ctrl #(
  parameter int unsigned SLOT_COUNT = 8,
  parameter int unsigned IdxW       = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ptts_pkg::ptts_sts_t   sts_i,
  output ptts_pkg::ptts_cmd_t   cmd_o,
  output logic [IdxW-1:0]       idx_o,
  output logic [IdxW-1:0]       rd_idx_o
);
  import ptts_pkg::*;

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SCmd   = 2'd1;
  localparam logic [1:0] SProc  = 2'd2;
  localparam logic [1:0] SFlush = 2'd3;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sts_i.in_tick ? SProc : SCmd;
        end
      end
      SCmd: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = SIdle;
        end
      end
      SProc: begin
        if (!sts_i.stall) begin
          cmd_o.step = 1'b1;
          if (idx_q == LastIdx) begin
            idx_d   = '0;
            state_d = SFlush;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      SFlush: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
        idx_d   = '0;
      end
    endcase
  end

  assign in_ready_o = (state_q == SIdle);
  assign idx_o      = idx_q;
  // table read is registered, so address it with the next index
  assign rd_idx_o   = idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

[hw/rtl/ptts_dp.sv]
// Datapath of the periodic task tick scheduler: slot table, command latch,
// held dispatch and output register. Depends on ptts_pkg.
module ptts_dp #(
  parameter int unsigned SLOT_COUNT = 8,
  parameter int unsigned IdxW       = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ptts_pkg::ptts_in_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ptts_pkg::ptts_out_t   out_data_o,
  input  ptts_pkg::ptts_cmd_t   cmd_i,
  input  logic [IdxW-1:0]       idx_i,
  input  logic [IdxW-1:0]       rd_idx_i,
  output ptts_pkg::ptts_sts_t   sts_o
);
  import ptts_pkg::*;

  // slot table: occupied marks in flops, the rest in memories
  logic [SLOT_COUNT-1:0] occ_q;
  logic                  susp_mem [SLOT_COUNT];
  logic [15:0]           per_mem  [SLOT_COUNT];
  logic [15:0]           cd_mem   [SLOT_COUNT];
  logic [15:0]           hdl_mem  [SLOT_COUNT];

  logic        susp_rd_q;
  logic [15:0] per_rd_q, cd_rd_q, hdl_rd_q;

  ptts_in_t  in_q;
  logic      out_valid_q;
  ptts_out_t out_q;

  logic            pend_valid_q;
  logic [IdxW-1:0] pend_slot_q;
  logic [15:0]     pend_hdl_q;
  logic [CntW-1:0] cnt_q;

  logic            in_range, cmd_occ, active, due, out_free;
  logic [IdxW-1:0] cmd_idx, wr_idx;
  logic [1:0]      status;
  logic            occ_set, occ_clr;
  logic            susp_we, susp_wd;
  logic            create_we, cd_we;
  logic [15:0]     cd_wd;

  assign in_range = (in_q.slot < 8'(SLOT_COUNT));
  assign cmd_idx  = in_q.slot[IdxW-1:0];
  assign cmd_occ  = in_range && occ_q[cmd_idx];
  assign active   = occ_q[idx_i] && !susp_rd_q;
  assign due      = active && (cd_rd_q == 16'd0) && (cnt_q < CntW'(MaxResults));
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.in_tick  = (in_data_i.operation == OpTick);
  assign sts_o.out_free = out_free;
  assign sts_o.stall    = due && pend_valid_q && !out_free;

  // command decode
  always_comb begin
    status    = StOk;
    occ_set   = 1'b0;
    occ_clr   = 1'b0;
    susp_we   = 1'b0;
    susp_wd   = 1'b0;
    create_we = 1'b0;
    case (in_q.operation)
      OpCreate: begin
        if (!in_range) begin
          status = StRange;
        end else if (cmd_occ) begin
          status = StOccupied;
        end else begin
          occ_set   = cmd_i.exec;
          susp_we   = cmd_i.exec;
          create_we = cmd_i.exec;
        end
      end
      OpDelete: begin
        if (!in_range) status = StRange;
        else occ_clr = cmd_i.exec;
      end
      OpSuspend: begin
        if (!in_range) begin
          status = StRange;
        end else begin
          susp_we = cmd_i.exec;
          susp_wd = 1'b1;
        end
      end
      OpResume: begin
        if (!in_range) status = StRange;
        else susp_we = cmd_i.exec;
      end
      default: status = StOk;
    endcase
  end

  // countdown update: loaded on create, stepped during a tick walk; a due slot past the cap is left alone
  always_comb begin
    cd_we = 1'b0;
    cd_wd = in_q.first_delay;
    if (create_we) begin
      cd_we = 1'b1;
    end else if (cmd_i.step && active) begin
      if (due) begin
        cd_we = 1'b1;
        cd_wd = per_rd_q - 16'd1;
      end else if (cd_rd_q != 16'd0) begin
        cd_we = 1'b1;
        cd_wd = cd_rd_q - 16'd1;
      end
    end
  end

  assign wr_idx = cmd_i.exec ? cmd_idx : idx_i;

  // memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (susp_we)   susp_mem[wr_idx] <= susp_wd;
    if (create_we) per_mem[wr_idx]  <= in_q.period;
    if (create_we) hdl_mem[wr_idx]  <= in_q.task_handle;
    if (cd_we)     cd_mem[wr_idx]   <= cd_wd;
    susp_rd_q <= susp_mem[rd_idx_i];
    per_rd_q  <= per_mem[rd_idx_i];
    cd_rd_q   <= cd_mem[rd_idx_i];
    hdl_rd_q  <= hdl_mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (occ_set) begin
      occ_q[cmd_idx] <= 1'b1;
    end else if (occ_clr) begin
      occ_q[cmd_idx] <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_data_i;
    if (cmd_i.step && due) begin
      pend_slot_q <= idx_i;
      pend_hdl_q  <= hdl_rd_q;
    end
    if (cmd_i.exec) begin
      out_q.kind              <= KindAck;
      out_q.status            <= status;
      out_q.dispatched_slot   <= '0;
      out_q.dispatched_handle <= '0;
      out_q.last              <= 1'b1;
    end else if (cmd_i.step && due && pend_valid_q) begin
      out_q.kind              <= KindDispatch;
      out_q.status            <= StOk;
      out_q.dispatched_slot   <= 6'(pend_slot_q);
      out_q.dispatched_handle <= pend_hdl_q;
      out_q.last              <= 1'b0;
    end else if (cmd_i.flush) begin
      out_q.kind              <= pend_valid_q ? KindDispatch : KindIdle;
      out_q.status            <= StOk;
      out_q.dispatched_slot   <= pend_valid_q ? 6'(pend_slot_q) : 6'd0;
      out_q.dispatched_handle <= pend_valid_q ? pend_hdl_q : 16'd0;
      out_q.last              <= 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (cmd_i.exec || cmd_i.flush || (cmd_i.step && due && pend_valid_q)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.capture || cmd_i.flush) begin
        pend_valid_q <= 1'b0;
        cnt_q        <= '0;
      end else if (cmd_i.step && due) begin
        pend_valid_q <= 1'b1;
        cnt_q        <= cnt_q + 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/periodic_task_tick_scheduler_core.sv]
// Periodic task tick scheduler, top level. Uses ptts_pkg, ptts_ctrl, ptts_dp.
// Input channel (in_valid_i/in_ready_o, in_data_i): one beat is a create,
// delete, suspend, resume or tick. Output channel (out_valid_o/out_ready_i,
// out_data_o): result beats; the final beat caused by an input has last set.
// Commands give one acknowledge beat, registered once the command is latched
// and the output register is free.
// A tick walks the slot table one slot per cycle while not halted, from
// slot 0 upward, then emits a closing beat. Each due slot's dispatch is held
// until the next due slot or the end of the walk, since only then is its last
// flag known; at most 8 dispatches come out per tick. The walk rate is set by
// the single registered read port of the slot memories.
// Stall: the output register holds a beat until taken; the block keeps
// accepting a new input meanwhile. A command's acknowledge and a tick's
// closing beat wait for the register to free, and a tick walk halts when a
// due slot is reached while a dispatch is held and the register is still full.
// Reset (rst_ni low, asynchronous) clears every occupied mark and all
// control state; other slot fields are written by create before use.
`include "periodic_task_tick_scheduler_core_macros.svh"

module periodic_task_tick_scheduler_core #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ptts_pkg::ptts_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ptts_pkg::ptts_out_t  out_data_o
);
  import ptts_pkg::*;

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  ptts_cmd_t       cmd;
  ptts_sts_t       sts;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] rd_idx;

  // sequencer
  ptts_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .IdxW       (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idx_o      (idx),
    .rd_idx_o   (rd_idx)
  );

  // slot table and result path
  ptts_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .IdxW       (IdxW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .rd_idx_i    (rd_idx),
    .sts_o       (sts)
  );

  // one input beat at a time: busy right after an accept
  `PTTS_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "accepted twice in a row")
  // a tick with nothing due always closes its result sequence
  `PTTS_ASSERT_IMP(a_idle_is_last, out_valid_o && (out_data_o.kind == KindIdle), out_data_o.last, "idle tick beat without last")
  // error status only ever rides on an acknowledge
  `PTTS_ASSERT_IMP(a_err_on_ack, out_valid_o && (out_data_o.status != StOk), out_data_o.kind == KindAck, "error status on non-ack beat")

endmodule
